// ===== hw/rtl/clab_pkg.sv =====
package clab_pkg;

   // Grid geometry
   localparam int MAX_GRID     = 16;
   localparam int SIDE         = MAX_GRID + 2;
   localparam int NBINS        = SIDE * SIDE * SIDE;
   localparam int BIN_CAPACITY = 32;

   // Field widths
   localparam int GRID_W     = 5;
   localparam int COORD_W    = 32;
   localparam int BIN_SIZE_W = 31;
   localparam int MASK_W     = 3;
   localparam int BIN_W      = 13;
   localparam int SLOT_IN_W  = 5;
   localparam int ID_W       = 20;
   localparam int CNT_OUT_W  = 6;
   localparam int STATUS_W   = 2;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;
   localparam int NXNY_W     = $clog2(SIDE * SIDE + 1);
   localparam int ACC_W      = COORD_W + GRID_W;

   // Commands
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_HALO   = 2'd1,
      CMD_READ   = 2'd2,
      CMD_CLEAR  = 2'd3
   } command_type;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_SIZE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIODIC = 3'd4;

   // Register reset values
   localparam logic [GRID_W-1:0]     GRID_RESET     = 5'd16;
   localparam logic [BIN_SIZE_W-1:0] BIN_SIZE_RESET = 31'd65536;
   localparam logic [MASK_W-1:0]     MASK_RESET     = 3'd7;

   // Per-axis bin search result
   typedef struct packed {
      logic              done;
      logic [GRID_W-1:0] bin;
   } axis_result_type;

endpackage

// ===== hw/rtl/clab_axis_bin.sv =====
module clab_axis_bin import clab_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_W-1:0]    raw,
   input  logic [BIN_SIZE_W-1:0] bin_size,
   input  logic [GRID_W-1:0]     grid,
   output axis_result_type       result
);

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic                nonpos_ff, nonpos_in;
   logic [COORD_W-1:0]  raw_ff, raw_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [GRID_W-1:0]   k_ff, k_in;
   logic                hit;

   // Stop at first k with raw <= k * bin_size, raw <= 0 or k >= grid
   assign hit = nonpos_ff || (ACC_W'(raw_ff) <= acc_ff) || (k_ff >= grid);

   always_comb begin
      run_in    = run_ff;
      done_in   = done_ff;
      nonpos_in = nonpos_ff;
      raw_in    = raw_ff;
      acc_in    = acc_ff;
      k_in      = k_ff;
      if (start) begin
         run_in    = 1'b1;
         done_in   = 1'b0;
         nonpos_in = (raw == '0) || raw[COORD_W-1];
         raw_in    = raw;
         acc_in    = ACC_W'(bin_size);
         k_in      = GRID_W'(1);
      end else if (run_ff) begin
         if (hit) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            k_in   = k_ff + GRID_W'(1);
            acc_in = acc_ff + ACC_W'(bin_size);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      nonpos_ff <= nonpos_in;
      raw_ff    <= raw_in;
      acc_ff    <= acc_in;
      k_ff      <= k_in;
   end

   assign result.done = done_ff;
   assign result.bin  = k_ff;

endmodule

// ===== hw/rtl/cell_list_atom_binning_top.sv =====
// Cell-list binning table over a 3-D grid padded with one halo layer per side.
// Command channel: a transfer happens on a clock edge with start high and busy
// low; req_command selects insert, fill halo, read entry or clear all.
// Result channel: rsp_valid is high for exactly one cycle per command, with the
// rsp_ fields valid in that cycle. The receiver cannot stall; every result is
// taken in the cycle it is shown. The next command may start in that cycle.
// Register port: csr_write_enable writes csr_write_data to register csr_index
// at once; write only while busy is low.
// Command steps, one command at a time:
//   insert: the three per-axis bin searches (one add and compare per cycle,
//     up to the grid size), then the count read-modify-write.
//   read:   a wait and a range check, then a walk down the z layers and y rows
//     below the bin, then the count and entry reads and the result.
//   halo:   a walk over every padded bin that copies each border bin from its
//     image through the single ports of both memories, count then entries.
//   clear:  a sweep that zeroes every bin count entry, then the result.
// After reset the block runs the same sweep over the bin counts with busy
// high and shows no result for it.
module cell_list_atom_binning_top import clab_pkg::*; #(
   parameter int BIN_CAP = BIN_CAPACITY
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [ID_W-1:0]       req_atom_id,
   input  logic [COORD_W-1:0]    req_pos_x,
   input  logic [COORD_W-1:0]    req_pos_y,
   input  logic [COORD_W-1:0]    req_pos_z,
   input  logic [BIN_W-1:0]      req_read_bin,
   input  logic [SLOT_IN_W-1:0]  req_read_slot,
   output logic                  rsp_valid,
   output logic [BIN_W-1:0]      rsp_bin_index,
   output logic [ID_W-1:0]       rsp_entry_id,
   output logic [CNT_OUT_W-1:0]  rsp_entry_count,
   output logic                  rsp_in_halo,
   output logic [STATUS_W-1:0]   rsp_status,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int SLOT_W = (BIN_CAP > 1) ? $clog2(BIN_CAP) : 1;
   localparam int CNT_W  = $clog2(BIN_CAP + 1);
   localparam int ENT_AW = BIN_W + SLOT_W;
   localparam int MUL_W  = BIN_W + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_DIV, S_INS_RD, S_INS_WR,
      S_RD_WAIT, S_RD_CHK, S_RD_Z, S_RD_Y, S_RD_OUT,
      S_HALO_SCAN, S_HALO_CNT, S_HALO_RD, S_HALO_WR
   } state_type;

   function automatic logic [GRID_W-1:0] eff_grid(input logic [GRID_W-1:0] v);
      logic [GRID_W-1:0] r;
      r = v;
      if (v == '0) r = GRID_W'(1);
      else if (32'(v) > MAX_GRID) r = GRID_W'(MAX_GRID);
      return r;
   endfunction

   function automatic logic [BIN_W-1:0] lin_index(
      input logic [GRID_W-1:0] x, input logic [GRID_W-1:0] y,
      input logic [GRID_W-1:0] z, input logic [GRID_W-1:0] nxv,
      input logic [NXNY_W-1:0] nxnyv);
      logic [MUL_W-1:0] s;
      s = MUL_W'(x) + MUL_W'(y) * MUL_W'(nxv) + MUL_W'(z) * MUL_W'(nxnyv);
      return BIN_W'(s);
   endfunction

   // Configuration registers
   logic [GRID_W-1:0]     grid_x_ff, grid_y_ff, grid_z_ff;
   logic [BIN_SIZE_W-1:0] bin_size_ff;
   logic [MASK_W-1:0]     mask_ff;
   logic [NXNY_W-1:0]     nxny_ff;
   logic [BIN_W-1:0]      nbins_ff;

   // Control and work registers
   state_type           state_ff, state_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [BIN_W-1:0]    rbin_ff, rbin_in;
   logic [SLOT_IN_W-1:0] slot_ff, slot_in;
   logic [BIN_W-1:0]    idx_ff, idx_in;
   logic [BIN_W-1:0]    rem_ff, rem_in;
   logic [GRID_W-1:0]   ry_ff, ry_in, rz_ff, rz_in;
   logic [GRID_W-1:0]   hx_ff, hx_in, hy_ff, hy_in, hz_ff, hz_in;
   logic [BIN_W-1:0]    src_ff, src_in, dst_ff, dst_in;
   logic [CNT_W-1:0]    ncopy_ff, ncopy_in;
   logic [SLOT_W-1:0]   cslot_ff, cslot_in;
   logic [BIN_W-1:0]    clr_ff, clr_in;
   logic                clr_rsp_ff, clr_rsp_in;

   // Result registers
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]     rsp_bin_ff, rsp_bin_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [CNT_OUT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                 rsp_border_ff, rsp_border_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   // Memory ports
   logic              cnt_we;
   logic [BIN_W-1:0]  cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]  cnt_wdata, cnt_rdata_ff;
   logic              ent_we;
   logic [ENT_AW-1:0] ent_waddr, ent_raddr;
   logic [ID_W-1:0]   ent_wdata, ent_rdata_ff;

   logic [CNT_W-1:0]  cnt_mem [NBINS];
   logic [ID_W-1:0]   ent_mem [NBINS * (2 ** SLOT_W)];

   // Derived geometry
   logic [GRID_W-1:0]     gx, gy, gz, nx, ny, nz;
   logic [BIN_SIZE_W-1:0] bs_eff;
   logic                  accept;
   axis_result_type       ax_x, ax_y, ax_z;
   logic                  ax_start;

   // Halo walk helpers
   logic                h_border, walk_done;
   logic [GRID_W-1:0]   sx, sy, sz, nhx, nhy, nhz;
   logic [BIN_W-1:0]    h_dst, h_src;

   // Read and insert helpers
   logic [GRID_W-1:0]   rx;
   logic                r_border, r_empty, ins_full;

   assign gx     = eff_grid(grid_x_ff);
   assign gy     = eff_grid(grid_y_ff);
   assign gz     = eff_grid(grid_z_ff);
   assign nx     = gx + GRID_W'(2);
   assign ny     = gy + GRID_W'(2);
   assign nz     = gz + GRID_W'(2);
   assign bs_eff = (bin_size_ff == '0) ? BIN_SIZE_W'(1) : bin_size_ff;
   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);
   assign ax_start = accept && (req_command == CMD_INSERT);

   // Per-axis bin search units
   clab_axis_bin u_axis_x (
      .clock(clock), .reset(reset), .start(ax_start), .raw(req_pos_x),
      .bin_size(bs_eff), .grid(gx), .result(ax_x));
   clab_axis_bin u_axis_y (
      .clock(clock), .reset(reset), .start(ax_start), .raw(req_pos_y),
      .bin_size(bs_eff), .grid(gy), .result(ax_y));
   clab_axis_bin u_axis_z (
      .clock(clock), .reset(reset), .start(ax_start), .raw(req_pos_z),
      .bin_size(bs_eff), .grid(gz), .result(ax_z));

   // Halo source and walk order: x outermost, z innermost
   always_comb begin
      h_border = (hx_ff == '0) || (hx_ff == gx + GRID_W'(1)) ||
                 (hy_ff == '0) || (hy_ff == gy + GRID_W'(1)) ||
                 (hz_ff == '0) || (hz_ff == gz + GRID_W'(1));
      sx = hx_ff;
      sy = hy_ff;
      sz = hz_ff;
      if (mask_ff[0]) begin
         if (hx_ff == '0) sx = gx;
         else if (hx_ff == gx + GRID_W'(1)) sx = GRID_W'(1);
      end
      if (mask_ff[1]) begin
         if (hy_ff == '0) sy = gy;
         else if (hy_ff == gy + GRID_W'(1)) sy = GRID_W'(1);
      end
      if (mask_ff[2]) begin
         if (hz_ff == '0) sz = gz;
         else if (hz_ff == gz + GRID_W'(1)) sz = GRID_W'(1);
      end
      h_dst = lin_index(hx_ff, hy_ff, hz_ff, nx, nxny_ff);
      h_src = lin_index(sx, sy, sz, nx, nxny_ff);
      nhx = hx_ff;
      nhy = hy_ff;
      nhz = hz_ff + GRID_W'(1);
      if (hz_ff == gz + GRID_W'(1)) begin
         nhz = '0;
         nhy = hy_ff + GRID_W'(1);
         if (hy_ff == gy + GRID_W'(1)) begin
            nhy = '0;
            nhx = hx_ff + GRID_W'(1);
         end
      end
      walk_done = (hx_ff == gx + GRID_W'(1)) && (hy_ff == gy + GRID_W'(1)) &&
                  (hz_ff == gz + GRID_W'(1));
   end

   // Read border flag, slot check and insert full check
   always_comb begin
      rx       = GRID_W'(rem_ff);
      r_border = (rx == '0) || (rx == gx + GRID_W'(1)) ||
                 (ry_ff == '0) || (ry_ff == gy + GRID_W'(1)) ||
                 (rz_ff == '0) || (rz_ff == gz + GRID_W'(1));
      r_empty  = (32'(slot_ff) >= 32'(cnt_rdata_ff)) || (32'(slot_ff) >= 32'(BIN_CAP));
      ins_full = 32'(cnt_rdata_ff) >= 32'(BIN_CAP);
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      id_in         = id_ff;
      rbin_in       = rbin_ff;
      slot_in       = slot_ff;
      idx_in        = idx_ff;
      rem_in        = rem_ff;
      ry_in         = ry_ff;
      rz_in         = rz_ff;
      hx_in         = hx_ff;
      hy_in         = hy_ff;
      hz_in         = hz_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      ncopy_in      = ncopy_ff;
      cslot_in      = cslot_ff;
      clr_in        = clr_ff;
      clr_rsp_in    = clr_rsp_ff;
      rsp_valid_in  = 1'b0;
      rsp_bin_in    = rsp_bin_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_border_in = rsp_border_ff;
      rsp_status_in = rsp_status_ff;
      cnt_we        = 1'b0;
      cnt_waddr     = idx_ff;
      cnt_wdata     = '0;
      cnt_raddr     = idx_ff;
      ent_we        = 1'b0;
      ent_waddr     = {dst_ff, cslot_ff};
      ent_wdata     = ent_rdata_ff;
      ent_raddr     = {src_ff, cslot_ff};

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_command)
                  CMD_INSERT: begin
                     id_in    = req_atom_id;
                     state_in = S_DIV;
                  end
                  CMD_HALO: begin
                     hx_in    = '0;
                     hy_in    = '0;
                     hz_in    = '0;
                     state_in = S_HALO_SCAN;
                  end
                  CMD_READ: begin
                     rbin_in  = req_read_bin;
                     slot_in  = req_read_slot;
                     rem_in   = req_read_bin;
                     ry_in    = '0;
                     rz_in    = '0;
                     state_in = S_RD_WAIT;
                  end
                  default: begin
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLEAR;
                  end
               endcase
            end
         end

         // Sweep the bin counts to zero
         S_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            cnt_wdata = '0;
            if (32'(clr_ff) == NBINS - 1) begin
               if (clr_rsp_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_bin_in    = '0;
                  rsp_id_in     = '0;
                  rsp_cnt_in    = '0;
                  rsp_border_in = 1'b0;
                  rsp_status_in = ST_OK;
               end
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + BIN_W'(1);
            end
         end

         // Wait for the three axis searches
         S_DIV: begin
            if (ax_x.done && ax_y.done && ax_z.done) begin
               idx_in   = lin_index(ax_x.bin, ax_y.bin, ax_z.bin, nx, nxny_ff);
               state_in = S_INS_RD;
            end
         end

         S_INS_RD: begin
            cnt_raddr = idx_ff;
            state_in  = S_INS_WR;
         end

         // Append the id unless the bin is full
         S_INS_WR: begin
            rsp_valid_in  = 1'b1;
            rsp_bin_in    = idx_ff;
            rsp_id_in     = id_ff;
            rsp_border_in = 1'b0;
            if (ins_full) begin
               rsp_cnt_in    = CNT_OUT_W'(cnt_rdata_ff);
               rsp_status_in = ST_FULL;
            end else begin
               ent_we        = 1'b1;
               ent_waddr     = {idx_ff, SLOT_W'(cnt_rdata_ff)};
               ent_wdata     = id_ff;
               cnt_we        = 1'b1;
               cnt_waddr     = idx_ff;
               cnt_wdata     = cnt_rdata_ff + CNT_W'(1);
               rsp_cnt_in    = CNT_OUT_W'(cnt_rdata_ff + CNT_W'(1));
               rsp_status_in = ST_OK;
            end
            state_in = S_IDLE;
         end

         S_RD_WAIT: begin
            state_in = S_RD_CHK;
         end

         S_RD_CHK: begin
            if (rbin_ff >= nbins_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_bin_in    = rbin_ff;
               rsp_id_in     = '0;
               rsp_cnt_in    = '0;
               rsp_border_in = 1'b0;
               rsp_status_in = ST_EMPTY;
               state_in      = S_IDLE;
            end else begin
               state_in = S_RD_Z;
            end
         end

         // Peel off z layers, then y rows
         S_RD_Z: begin
            if (rem_ff >= BIN_W'(nxny_ff)) begin
               rem_in = rem_ff - BIN_W'(nxny_ff);
               rz_in  = rz_ff + GRID_W'(1);
            end else begin
               state_in = S_RD_Y;
            end
         end

         S_RD_Y: begin
            if (rem_ff >= BIN_W'(nx)) begin
               rem_in = rem_ff - BIN_W'(nx);
               ry_in  = ry_ff + GRID_W'(1);
            end else begin
               cnt_raddr = rbin_ff;
               ent_raddr = {rbin_ff, SLOT_W'(slot_ff)};
               state_in  = S_RD_OUT;
            end
         end

         S_RD_OUT: begin
            rsp_valid_in  = 1'b1;
            rsp_bin_in    = rbin_ff;
            rsp_id_in     = r_empty ? '0 : ent_rdata_ff;
            rsp_cnt_in    = CNT_OUT_W'(cnt_rdata_ff);
            rsp_border_in = r_border;
            rsp_status_in = r_empty ? ST_EMPTY : ST_OK;
            state_in      = S_IDLE;
         end

         // Visit each padded bin; copy border bins from their image
         S_HALO_SCAN: begin
            if (h_border && (h_dst != h_src)) begin
               src_in    = h_src;
               dst_in    = h_dst;
               cnt_raddr = h_src;
               state_in  = S_HALO_CNT;
            end else if (walk_done) begin
               rsp_valid_in  = 1'b1;
               rsp_bin_in    = '0;
               rsp_id_in     = '0;
               rsp_cnt_in    = '0;
               rsp_border_in = 1'b0;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end else begin
               hx_in = nhx;
               hy_in = nhy;
               hz_in = nhz;
            end
         end

         S_HALO_CNT: begin
            cnt_we    = 1'b1;
            cnt_waddr = dst_ff;
            cnt_wdata = cnt_rdata_ff;
            ncopy_in  = cnt_rdata_ff;
            cslot_in  = '0;
            if (cnt_rdata_ff != '0) begin
               state_in = S_HALO_RD;
            end else if (walk_done) begin
               rsp_valid_in  = 1'b1;
               rsp_bin_in    = '0;
               rsp_id_in     = '0;
               rsp_cnt_in    = '0;
               rsp_border_in = 1'b0;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end else begin
               hx_in    = nhx;
               hy_in    = nhy;
               hz_in    = nhz;
               state_in = S_HALO_SCAN;
            end
         end

         S_HALO_RD: begin
            ent_raddr = {src_ff, cslot_ff};
            state_in  = S_HALO_WR;
         end

         // Move one entry, then advance or finish the bin
         S_HALO_WR: begin
            ent_we    = 1'b1;
            ent_waddr = {dst_ff, cslot_ff};
            ent_wdata = ent_rdata_ff;
            if (CNT_W'(cslot_ff) + CNT_W'(1) != ncopy_ff) begin
               cslot_in = cslot_ff + SLOT_W'(1);
               state_in = S_HALO_RD;
            end else if (walk_done) begin
               rsp_valid_in  = 1'b1;
               rsp_bin_in    = '0;
               rsp_id_in     = '0;
               rsp_cnt_in    = '0;
               rsp_border_in = 1'b0;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end else begin
               hx_in    = nhx;
               hy_in    = nhy;
               hz_in    = nhz;
               state_in = S_HALO_SCAN;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, configuration and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         grid_x_ff    <= GRID_RESET;
         grid_y_ff    <= GRID_RESET;
         grid_z_ff    <= GRID_RESET;
         bin_size_ff  <= BIN_SIZE_RESET;
         mask_ff      <= MASK_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_GRID_X:   grid_x_ff   <= GRID_W'(csr_write_data);
               CSR_GRID_Y:   grid_y_ff   <= GRID_W'(csr_write_data);
               CSR_GRID_Z:   grid_z_ff   <= GRID_W'(csr_write_data);
               CSR_BIN_SIZE: bin_size_ff <= csr_write_data;
               CSR_PERIODIC: mask_ff     <= MASK_W'(csr_write_data);
               default: begin
               end
            endcase
         end
      end
      nxny_ff       <= NXNY_W'(MUL_W'(nx) * MUL_W'(ny));
      nbins_ff      <= BIN_W'(MUL_W'(nxny_ff) * MUL_W'(nz));
      id_ff         <= id_in;
      rbin_ff       <= rbin_in;
      slot_ff       <= slot_in;
      idx_ff        <= idx_in;
      rem_ff        <= rem_in;
      ry_ff         <= ry_in;
      rz_ff         <= rz_in;
      hx_ff         <= hx_in;
      hy_ff         <= hy_in;
      hz_ff         <= hz_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      ncopy_ff      <= ncopy_in;
      cslot_ff      <= cslot_in;
      rsp_bin_ff    <= rsp_bin_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_border_ff <= rsp_border_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Bin count memory
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rdata_ff <= cnt_mem[cnt_raddr];
   end

   // Bin entry memory
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      ent_rdata_ff <= ent_mem[ent_raddr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bin_index   = rsp_bin_ff;
   assign rsp_entry_id    = rsp_id_ff;
   assign rsp_entry_count = rsp_cnt_ff;
   assign rsp_in_halo     = rsp_border_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Cell-list table tracker: mirrors bin counts and entries, queues expected responses.
class bin_table_tracker;
   typedef struct {
      logic [12:0] bin;
      logic [19:0] id;
      logic [5:0]  cnt;
      logic        border;
      logic [1:0]  status;
   } bin_response_type;

   logic [5:0]  counts[clab_pkg::NBINS];
   logic [19:0] entries[clab_pkg::NBINS * clab_pkg::BIN_CAPACITY];
   logic [4:0]  grid_x, grid_y, grid_z;
   logic [30:0] bin_size;
   logic [2:0]  periodic;
   bin_response_type pending_q[$];
   int errors;

   function new();
      grid_x = 16; grid_y = 16; grid_z = 16;
      bin_size = 31'd65536; periodic = 3'd7;
      errors = 0;
      foreach (counts[i]) counts[i] = 0;
      foreach (entries[i]) entries[i] = 0;
   endfunction

   function void set_reg(logic [2:0] idx, logic [30:0] val);
      case (idx)
         clab_pkg::CSR_GRID_X:   grid_x = val[4:0];
         clab_pkg::CSR_GRID_Y:   grid_y = val[4:0];
         clab_pkg::CSR_GRID_Z:   grid_z = val[4:0];
         clab_pkg::CSR_BIN_SIZE: bin_size = val;
         clab_pkg::CSR_PERIODIC: periodic = val[2:0];
         default: ;
      endcase
   endfunction

   function int eff(logic [4:0] v);
      if (v < 1) return 1;
      if (v > clab_pkg::MAX_GRID) return clab_pkg::MAX_GRID;
      return v;
   endfunction

   function int axis_bin(logic [31:0] raw, longint bs, int g);
      longint q;
      if (raw == 0 || raw[31]) return 1;
      q = (longint'(raw) + bs - 1) / bs;
      if (q > g) q = g;
      if (q < 1) q = 1;
      return int'(q);
   endfunction

   function void copy_bin(int dst, int src);
      if (dst == src) return;
      counts[dst] = counts[src];
      for (int s = 0; s < clab_pkg::BIN_CAPACITY; s++)
         entries[dst * clab_pkg::BIN_CAPACITY + s] = entries[src * clab_pkg::BIN_CAPACITY + s];
   endfunction

   // Copy every border bin from its periodic image, x outermost, in place.
   function void fill_halo(int gx, int gy, int gz);
      int nx, ny, nz, sx, sy, sz;
      nx = gx + 2; ny = gy + 2; nz = gz + 2;
      for (int x = 0; x < nx; x++)
         for (int y = 0; y < ny; y++)
            for (int z = 0; z < nz; z++) begin
               if (!(x == 0 || x == gx + 1 || y == 0 || y == gy + 1 || z == 0 || z == gz + 1))
                  continue;
               sx = x; sy = y; sz = z;
               if (periodic[0]) begin
                  if (x == 0) sx = gx; else if (x == gx + 1) sx = 1;
               end
               if (periodic[1]) begin
                  if (y == 0) sy = gy; else if (y == gy + 1) sy = 1;
               end
               if (periodic[2]) begin
                  if (z == 0) sz = gz; else if (z == gz + 1) sz = 1;
               end
               copy_bin(x + y * nx + z * nx * ny, sx + sy * nx + sz * nx * ny);
            end
   endfunction

   // Apply one accepted command and queue its response.
   function void note(clab_pkg::command_type cmd, logic [19:0] atom, logic [31:0] px,
                      logic [31:0] py, logic [31:0] pz, logic [12:0] rbin, logic [4:0] slot);
      bin_response_type r;
      int gx, gy, gz, nx, ny, nz, idx, k, x, y, z;
      longint bs;
      gx = eff(grid_x); gy = eff(grid_y); gz = eff(grid_z);
      nx = gx + 2; ny = gy + 2; nz = gz + 2;
      r = '{default: 0};
      case (cmd)
         clab_pkg::CMD_INSERT: begin
            bs = (bin_size == 0) ? 1 : longint'(bin_size);
            idx = axis_bin(px, bs, gx) + axis_bin(py, bs, gy) * nx
                  + axis_bin(pz, bs, gz) * nx * ny;
            k = counts[idx];
            r.id = atom;
            if (k >= clab_pkg::BIN_CAPACITY) begin
               r.status = clab_pkg::ST_FULL;
            end else begin
               entries[idx * clab_pkg::BIN_CAPACITY + k] = atom;
               counts[idx] = k + 1;
            end
            r.bin = idx;
            r.cnt = counts[idx];
         end
         clab_pkg::CMD_HALO: fill_halo(gx, gy, gz);
         clab_pkg::CMD_READ: begin
            r.bin = rbin;
            if (rbin >= nx * ny * nz) begin
               r.status = clab_pkg::ST_EMPTY;
            end else begin
               x = rbin % nx; y = (rbin / nx) % ny; z = rbin / (nx * ny);
               r.border = (x == 0 || x == gx + 1 || y == 0 || y == gy + 1 ||
                           z == 0 || z == gz + 1);
               r.cnt = counts[rbin];
               if (slot >= r.cnt) r.status = clab_pkg::ST_EMPTY;
               else r.id = entries[rbin * clab_pkg::BIN_CAPACITY + slot];
            end
         end
         default: foreach (counts[i]) counts[i] = 0;
      endcase
      pending_q.push_back(r);
   endfunction

   function void cmp(string name, logic [19:0] e, logic [19:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, e, a);
         errors++;
      end
   endfunction

   function void check(logic [12:0] bin, logic [19:0] id, logic [5:0] cnt,
                       logic border, logic [1:0] status);
      bin_response_type e;
      if (pending_q.size() == 0) begin
         $display("%0t: response with none expected, actual bin %0h", $realtime, bin);
         errors++;
         return;
      end
      e = pending_q.pop_front();
      cmp("bin_index", e.bin, bin);
      cmp("entry_id", e.id, id);
      cmp("entry_count", e.cnt, cnt);
      cmp("in_halo", e.border, border);
      cmp("status", e.status, status);
   endfunction
endclass

module testbench;
   import clab_pkg::*;

   localparam int IDLE_LIMIT = 400000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  start = 0;
   logic                  busy;
   logic [CMD_W-1:0]      req_command = 0;
   logic [ID_W-1:0]       req_atom_id = 0;
   logic [COORD_W-1:0]    req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic [BIN_W-1:0]      req_read_bin = 0;
   logic [SLOT_IN_W-1:0]  req_read_slot = 0;
   logic                  rsp_valid;
   logic [BIN_W-1:0]      rsp_bin_index;
   logic [ID_W-1:0]       rsp_entry_id;
   logic [CNT_OUT_W-1:0]  rsp_entry_count;
   logic                  rsp_in_halo;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_write_enable = 0;
   logic [CSR_IDX_W-1:0]  csr_index = 0;
   logic [CSR_DATA_W-1:0] csr_write_data = 0;

   bin_table_tracker table_model = new();
   bit gaps_on;
   int idle_cycles;
   int insert_bins[$];

   cell_list_atom_binning_top u_top (.*);

   initial forever #1 clock = ~clock;

   // Track transfers and responses; count cycles with no progress.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            table_model.check(rsp_bin_index, rsp_entry_id, rsp_entry_count,
                              rsp_in_halo, rsp_status);
         if (start && !busy) begin
            table_model.note(command_type'(req_command), req_atom_id, req_pos_x,
                             req_pos_y, req_pos_z, req_read_bin, req_read_slot);
            // Remember recent insert bins for targeted reads
            if (req_command == CMD_INSERT) begin
               insert_bins.push_back(table_model.pending_q[$].bin);
               if (insert_bins.size() > 64) void'(insert_bins.pop_front());
            end
         end
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   task automatic send(command_type cmd, logic [19:0] atom, logic [31:0] px,
                       logic [31:0] py, logic [31:0] pz, logic [12:0] rbin,
                       logic [4:0] slot);
      if (gaps_on && $urandom_range(0, 99) < 14) begin
         start <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1;
      req_command <= cmd;
      req_atom_id <= atom;
      req_pos_x <= px; req_pos_y <= py; req_pos_z <= pz;
      req_read_bin <= rbin;
      req_read_slot <= slot;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drain responses, then hold off before touching registers.
   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (table_model.pending_q.size() != 0 || busy) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [30:0] val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      table_model.set_reg(idx, val);
   endtask

   task automatic set_grid(logic [4:0] gx, logic [4:0] gy, logic [4:0] gz,
                           logic [30:0] bs, logic [2:0] mask);
      write_reg(CSR_GRID_X, gx);
      write_reg(CSR_GRID_Y, gy);
      write_reg(CSR_GRID_Z, gz);
      write_reg(CSR_BIN_SIZE, bs);
      write_reg(CSR_PERIODIC, mask);
      insert_bins.delete();
   endtask

   function automatic logic [31:0] pick_pos(logic [4:0] g);
      longint bs, lim;
      bs = (table_model.bin_size == 0) ? 1 : table_model.bin_size;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 0;
         2: return 32'h8000_0000 | $urandom;
         3: return 32'h7fff_ffff;
         default: begin
            lim = (table_model.eff(g) + 1) * bs;
            if (lim > 64'h7fff_ffff) lim = 64'h7fff_ffff;
            return $urandom_range(0, int'(lim));
         end
      endcase
   endfunction

   task automatic random_item();
      int r, b, c;
      r = $urandom_range(0, 99);
      if (r < 56) begin
         send(CMD_INSERT, $urandom, pick_pos(table_model.grid_x),
              pick_pos(table_model.grid_y), pick_pos(table_model.grid_z),
              $urandom, $urandom);
      end else if (r < 96) begin
         if (insert_bins.size() != 0 && $urandom_range(0, 9) < 7) begin
            b = insert_bins[$urandom_range(0, insert_bins.size() - 1)];
            c = table_model.counts[b];
            send(CMD_READ, $urandom, $urandom, $urandom, $urandom, b,
                 $urandom_range(0, (c > 31) ? 31 : c));
         end else begin
            send(CMD_READ, $urandom, $urandom, $urandom, $urandom,
                 $urandom_range(0, 8191), $urandom);
         end
      end else if (r < 98) begin
         send(CMD_HALO, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
         send(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (busy) @(posedge clock);
      gaps_on = 1;

      // Directed: extremes of coordinates and ids, halo copy, empty and out-of-range reads.
      send(CMD_INSERT, 20'h00000, 0, 0, 0, 0, 0);
      send(CMD_INSERT, 20'hfffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
      send(CMD_INSERT, 20'h5a5a5, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0001, 0, 0);
      send(CMD_INSERT, 20'h12345, 32'd65536, 32'd65537, 32'd131072, 0, 0);
      send(CMD_READ, 0, 0, 0, 0, 13'd343, 5'd0);
      send(CMD_READ, 0, 0, 0, 0, 13'd343, 5'd2);
      send(CMD_READ, 0, 0, 0, 0, 13'd343, 5'd31);
      send(CMD_READ, 0, 0, 0, 0, 13'd16 + 16 * 18 + 16 * 324, 5'd0);
      send(CMD_READ, 0, 0, 0, 0, 13'h1fff, 5'd0);
      send(CMD_READ, 0, 0, 0, 0, 13'd5831, 5'd0);
      send(CMD_READ, 0, 0, 0, 0, 13'd0, 5'd0);
      send(CMD_HALO, 0, 0, 0, 0, 0, 0);
      send(CMD_READ, 0, 0, 0, 0, 13'd17 + 18 + 324, 5'd0);
      send(CMD_READ, 0, 0, 0, 0, 13'd0, 5'd1);
      send(CMD_READ, 0, 0, 0, 0, 13'd5831, 5'd0);
      send(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
      send(CMD_READ, 0, 0, 0, 0, 13'd343, 5'd0);

      // Random phases over several register settings.
      for (int p = 0; p < 12; p++) begin
         drain();
         case (p)
            0: set_grid(1, 1, 1, 31'd1, 3'd0);
            1: set_grid(2, 3, 4, 31'd65536, 3'd5);
            2: set_grid(0, 31, 16, 31'h7fff_ffff, 3'd2);
            3: set_grid(16, 16, 16, 31'd0, 3'd7);
            4: set_grid(1, 2, 1, 31'd4096, 3'd3);
            default: set_grid($urandom_range(0, 9) ? $urandom_range(0, 5) : 31,
                              $urandom_range(0, 9) ? $urandom_range(0, 5) : 31,
                              $urandom_range(0, 9) ? $urandom_range(0, 5) : 31,
                              $urandom_range(0, 2) == 0 ? $urandom :
                                 $urandom_range(1, 1 << 20),
                              $urandom);
         endcase
         gaps_on = !(p == 5 || p == 9);
         repeat (150) random_item();
      end

      drain();
      if (table_model.errors == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end
endmodule

// ===== sim.f =====
hw/rtl/clab_pkg.sv
hw/rtl/clab_axis_bin.sv
hw/rtl/cell_list_atom_binning_top.sv
tb/sv/testbench.sv
